[src/dkr_pkg.sv]
// ----------------------------------------------------------------------------
// dkr_pkg
// Shared types and constants of the debounced key report slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package dkr_pkg;

  // Default sizes of the key table and the report
  localparam int NUM_KEYS_DEF  = 40;
  localparam int NUM_SLOTS_DEF = 6;
  // Report always carries this many key fields
  localparam int MAX_SLOTS     = 6;
  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH   = 2;

  // Field widths of an input item
  localparam int KEY_IDX_W = 6;
  localparam int SHIFT_W   = 6;
  localparam int CODE_W    = 8;
  localparam int MOD_W     = 8;

  // Owner codes of the key table: slot numbers below, then these
  localparam logic [2:0] OWN_MOD  = 3'd6;
  localparam logic [2:0] OWN_NONE = 3'd7;

  // Command kinds produced by the front
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_DOWN,
    CMD_UP
  } cmd_kind_t;

  // One classified item as it travels through the queue
  typedef struct packed {
    cmd_kind_t              kind;
    logic [KEY_IDX_W-1:0]   key_index;
    logic [SHIFT_W-1:0]     shift_index;
    logic                   has_mapping;
    logic [CODE_W-1:0]      keycode;
    logic [MOD_W-1:0]       modifier_mask;
    logic                   modifier_only;
    logic                   use_held_modifiers;
  } cmd_t;

endpackage

`default_nettype wire

[src/dkr_queue.sv]
// ----------------------------------------------------------------------------
// dkr_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dkr_queue
  import dkr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             q_mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push    = wr_en && !full;
  assign pop     = rd_en && !empty;
  assign rd_data = q_mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/dkr_front.sv]
// ----------------------------------------------------------------------------
// dkr_front
// Input side: accepts items, drops samples of keys outside the matrix and
// classifies the rest into tick, down and up commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dkr_front
  import dkr_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_func,
  input  wire logic [KEY_IDX_W-1:0] in_key_index,
  input  wire logic                 in_key_level,
  input  wire logic [SHIFT_W-1:0]   in_shift_index,
  input  wire logic                 in_has_mapping,
  input  wire logic [CODE_W-1:0]    in_keycode,
  input  wire logic [MOD_W-1:0]     in_modifier_mask,
  input  wire logic                 in_modifier_only,
  input  wire logic                 in_use_held_modifiers,
  input  wire logic                 q_full,
  output logic                      q_wr_en,
  output cmd_t                      q_wr_data
);

  localparam logic [7:0] KEY_LIMIT = 8'(NUM_KEYS);

  logic in_range;

  // Hold the input while the queue is full
  assign in_stall = q_full;
  assign in_range = ({2'b00, in_key_index} < KEY_LIMIT);

  // Classify and push; out-of-range samples are dropped here
  always_comb begin
    q_wr_data.kind               = in_func ? CMD_TICK : (in_key_level ? CMD_DOWN : CMD_UP);
    q_wr_data.key_index          = in_key_index;
    q_wr_data.shift_index        = in_shift_index;
    q_wr_data.has_mapping        = in_has_mapping;
    q_wr_data.keycode            = in_keycode;
    q_wr_data.modifier_mask      = in_modifier_mask;
    q_wr_data.modifier_only      = in_modifier_only;
    q_wr_data.use_held_modifiers = in_use_held_modifiers;
    q_wr_en = in_valid && !q_full && (in_func || in_range);
  end

endmodule

`default_nettype wire

[src/dkr_back.sv]
// ----------------------------------------------------------------------------
// dkr_back
// Execution side: per-key debounce and owner table in memory, report slots,
// held modifiers and the report output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dkr_back
  import dkr_pkg::*;
#(
  parameter int NUM_KEYS  = NUM_KEYS_DEF,
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire cmd_t              q_rd_data,
  output logic                   q_rd_en,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CODE_W-1:0]      out_keys [MAX_SLOTS],
  output logic [MOD_W-1:0]       out_modifier_byte,
  output logic                   out_last
);

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int EXT_W = (KEY_W > KEY_IDX_W) ? KEY_W : KEY_IDX_W;
  localparam int CNT_W = $clog2(NUM_KEYS + 1);

  // Debounce phases
  typedef enum logic [1:0] {
    PH_UP,
    PH_GO_DOWN,
    PH_DOWN,
    PH_GO_UP
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] owner;
  } key_ent_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT1,
    S_EMIT2
  } state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [EXT_W-1:0]   head_ext;
  logic [KEY_W-1:0]   head_key;

  key_ent_t           key_mem [NUM_KEYS];
  key_ent_t           rd_q_r;
  logic               mem_we;
  key_ent_t           mem_wdata;

  logic [NUM_KEYS-1:0]  phase_vld_r;
  logic [NUM_KEYS-1:0]  own_vld_r;
  logic [CNT_W-1:0]     own_cnt_r;
  logic [NUM_SLOTS-1:0] slot_busy_r;
  logic [CODE_W-1:0]    report_keys_r [NUM_SLOTS];
  logic [MOD_W-1:0]     report_mod_r;
  logic [MOD_W-1:0]     held_r;
  logic [SHIFT_W-1:0]   cur_shift_r;
  logic                 clear_pend_r;

  logic                 out_valid_r;
  logic [CODE_W-1:0]    out_keys_r [MAX_SLOTS];
  logic [MOD_W-1:0]     out_mod_r;
  logic                 out_last_r;

  logic [CODE_W-1:0]    rep_keys [MAX_SLOTS];
  logic                 out_free;
  logic                 emit_go;

  // Execute-step decisions
  phase_t               phase_cur;
  logic [2:0]           owner_cur;
  phase_t               phase_nxt;
  logic [2:0]           owner_nxt;
  logic [MOD_W-1:0]     held_nxt;
  logic [MOD_W-1:0]     rmod_nxt;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [NUM_SLOTS-1:0] take_vec;
  logic [NUM_SLOTS-1:0] rel_vec;
  logic [NUM_SLOTS-1:0] free_oh;
  logic [2:0]           free_idx;
  logic                 free_found;
  logic                 code_match;
  logic                 do_press;
  logic                 do_release;
  logic                 emit_one;
  logic                 is_tick;
  logic                 tick_chg;

  assign head_ext = EXT_W'(q_rd_data.key_index);
  assign head_key = head_ext[KEY_W-1:0];
  assign q_rd_en  = (state_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;
  assign emit_go  = (state_r inside {S_EMIT1, S_EMIT2}) && out_free;
  assign is_tick  = (cmd_r.kind == CMD_TICK);
  assign tick_chg = is_tick && (cmd_r.shift_index != cur_shift_r);

  // Widen the report to six fields; slots beyond the configured count read 0
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_rep
    if (g < NUM_SLOTS) begin : g_used
      assign rep_keys[g] = report_keys_r[g];
    end else begin : g_unused
      assign rep_keys[g] = '0;
    end
  end

  // Key table: one read port at pop, one write port at execute
  always_ff @(posedge clk) begin
    rd_q_r <= key_mem[head_key];
    if (mem_we) begin
      key_mem[key_r] <= mem_wdata;
    end
  end

  assign mem_we    = (state_r == S_EXEC) && !is_tick;
  assign mem_wdata = '{phase: phase_nxt, owner: owner_nxt};

  // Find a matching keycode and the lowest free slot
  always_comb begin
    code_match = 1'b0;
    free_found = 1'b0;
    free_oh    = '0;
    free_idx   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (report_keys_r[i] == cmd_r.keycode) begin
        code_match = 1'b1;
      end
      if (!slot_busy_r[i] && !free_found) begin
        free_found = 1'b1;
        free_oh[i] = 1'b1;
        free_idx   = 3'(i);
      end
    end
  end

  // Work out the effect of one sample
  always_comb begin
    phase_cur = phase_vld_r[key_r] ? rd_q_r.phase : PH_UP;
    owner_cur = own_vld_r[key_r] ? rd_q_r.owner : OWN_NONE;
    phase_nxt = phase_cur;
    owner_nxt = owner_cur;
    held_nxt  = held_r;
    rmod_nxt  = report_mod_r;
    take_vec  = '0;
    rel_vec   = '0;
    emit_one  = 1'b0;
    cnt_nxt   = own_cnt_r;

    do_press   = (cmd_r.kind == CMD_DOWN) && (phase_cur == PH_GO_DOWN);
    do_release = (cmd_r.kind == CMD_UP) && (phase_cur == PH_GO_UP);

    // advance debounce phase
    case (cmd_r.kind)
      CMD_DOWN: begin
        if (phase_cur == PH_UP) begin
          phase_nxt = PH_GO_DOWN;
        end else if (phase_cur == PH_GO_DOWN) begin
          phase_nxt = PH_DOWN;
        end
      end
      CMD_UP: begin
        if (phase_cur == PH_GO_DOWN || phase_cur == PH_GO_UP) begin
          phase_nxt = PH_UP;
        end else if (phase_cur == PH_DOWN) begin
          phase_nxt = PH_GO_UP;
        end
      end
      default: phase_nxt = phase_cur;
    endcase

    // confirmed press: hold modifiers or take a slot
    if (do_press && cmd_r.has_mapping) begin
      if (cmd_r.modifier_only) begin
        held_nxt  = held_r | cmd_r.modifier_mask;
        owner_nxt = OWN_MOD;
      end else if (!code_match && free_found) begin
        take_vec  = free_oh;
        owner_nxt = free_idx;
        rmod_nxt  = cmd_r.use_held_modifiers ? held_r : cmd_r.modifier_mask;
        emit_one  = 1'b1;
      end
    end

    // confirmed release: drop modifiers or free the slot
    if (do_release) begin
      if (owner_cur == OWN_MOD) begin
        if (cmd_r.modifier_only) begin
          held_nxt = held_r & ~cmd_r.modifier_mask;
          rmod_nxt = held_r & ~cmd_r.modifier_mask;
        end
        owner_nxt = OWN_NONE;
      end else if (owner_cur < 3'(NUM_SLOTS)) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          rel_vec[i] = (owner_cur == 3'(i));
        end
        owner_nxt = OWN_NONE;
      end
      emit_one = 1'b1;
    end

    // track how many keys own something
    if (owner_cur == OWN_NONE && owner_nxt != OWN_NONE) begin
      cnt_nxt = own_cnt_r + 1'b1;
    end else if (owner_cur != OWN_NONE && owner_nxt == OWN_NONE) begin
      cnt_nxt = own_cnt_r - 1'b1;
    end
  end

  // Sequencer, table state and report register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_vld_r  <= '0;
      own_vld_r    <= '0;
      own_cnt_r    <= '0;
      slot_busy_r  <= '0;
      report_mod_r <= '0;
      held_r       <= '0;
      cur_shift_r  <= '0;
      clear_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        report_keys_r[i] <= '0;
      end
    end else begin
      // raise the report when sent, drop it once taken
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_rd_data;
            key_r   <= head_key;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (is_tick) begin
            clear_pend_r <= 1'b0;
            if (tick_chg) begin
              own_vld_r    <= '0;
              own_cnt_r    <= '0;
              slot_busy_r  <= '0;
              report_mod_r <= '0;
              held_r       <= '0;
              cur_shift_r  <= cmd_r.shift_index;
              for (int i = 0; i < NUM_SLOTS; i++) begin
                report_keys_r[i] <= '0;
              end
              state_r <= S_EMIT1;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            phase_vld_r[key_r] <= 1'b1;
            own_vld_r[key_r]   <= 1'b1;
            own_cnt_r          <= cnt_nxt;
            held_r             <= held_nxt;
            report_mod_r       <= rmod_nxt;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (take_vec[i]) begin
                slot_busy_r[i]   <= 1'b1;
                report_keys_r[i] <= cmd_r.keycode;
              end else if (rel_vec[i]) begin
                slot_busy_r[i]   <= 1'b0;
                report_keys_r[i] <= '0;
              end
            end
            clear_pend_r <= do_release && (cnt_nxt == '0);
            state_r      <= emit_one ? S_EMIT1 : S_IDLE;
          end
        end
        S_EMIT1: begin
          if (out_free) begin
            out_keys_r  <= rep_keys;
            out_mod_r   <= report_mod_r;
            out_last_r  <= !clear_pend_r;
            if (clear_pend_r) begin
              // nothing held any more: clear all slots and owners
              own_vld_r    <= '0;
              own_cnt_r    <= '0;
              slot_busy_r  <= '0;
              report_mod_r <= '0;
              held_r       <= '0;
              for (int i = 0; i < NUM_SLOTS; i++) begin
                report_keys_r[i] <= '0;
              end
              state_r <= S_EMIT2;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_EMIT2: begin
          if (out_free) begin
            out_keys_r  <= rep_keys;
            out_mod_r   <= report_mod_r;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_keys          = out_keys_r;
  assign out_modifier_byte = out_mod_r;
  assign out_last          = out_last_r;

`ifndef ASSERT_OFF
  // The owner count never exceeds the number of keys
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    own_cnt_r <= CNT_W'(NUM_KEYS))
    else $error("owner count out of range");

  // A changed shift index leaves nothing held or owned
  a_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && tick_chg) |=> (own_cnt_r == '0 && held_r == '0 && slot_busy_r == '0))
    else $error("shift change did not clear");

  // The report before an all-clear is not the last one
  a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT1 && out_free && clear_pend_r) |=>
      (out_valid_r && !out_last_r && state_r == S_EMIT2))
    else $error("first of two reports marked last");

  // The all-clear report is empty and last
  a_clear_report: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT2 && out_free) |=> (out_valid_r && out_last_r && out_mod_r == '0))
    else $error("all-clear report malformed");
`endif

endmodule

`default_nettype wire

[src/debounced_key_report_slot_allocator.sv]
// ----------------------------------------------------------------------------
// debounced_key_report_slot_allocator
// Debounces key scan samples, allocates report slots for pressed keys, tracks
// held modifiers and emits key reports; shift changes clear the report.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in_     | input     | in_valid/in_stall   | func, key, level, shift, keymap
//   out_    | output    | out_valid/out_stall | six keycodes, modifier byte, last
//
// An item passes through the back's sequencer: key table read, execute, then
// one report step per report, if it emits any.
// A two-entry queue lets the front accept items while the back works.
// Reset is synchronous and clears the key table through valid bits at once.
// A stalled output holds the back in its report step; items queue up ahead.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_key_report_slot_allocator
  import dkr_pkg::*;
#(
  parameter int NUM_KEYS  = NUM_KEYS_DEF,
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_func,
  input  wire logic [KEY_IDX_W-1:0] in_key_index,
  input  wire logic                 in_key_level,
  input  wire logic [SHIFT_W-1:0]   in_shift_index,
  input  wire logic                 in_has_mapping,
  input  wire logic [CODE_W-1:0]    in_keycode,
  input  wire logic [MOD_W-1:0]     in_modifier_mask,
  input  wire logic                 in_modifier_only,
  input  wire logic                 in_use_held_modifiers,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CODE_W-1:0]         out_report_key0,
  output logic [CODE_W-1:0]         out_report_key1,
  output logic [CODE_W-1:0]         out_report_key2,
  output logic [CODE_W-1:0]         out_report_key3,
  output logic [CODE_W-1:0]         out_report_key4,
  output logic [CODE_W-1:0]         out_report_key5,
  output logic [MOD_W-1:0]          out_report_modifier_byte,
  output logic                      out_last
);

  logic              q_full;
  logic              q_empty;
  logic              q_wr_en;
  logic              q_rd_en;
  cmd_t              q_wr_data;
  cmd_t              q_rd_data;
  logic [CODE_W-1:0] out_keys [MAX_SLOTS];

  // Accept and classify
  dkr_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_func               (in_func),
    .in_key_index          (in_key_index),
    .in_key_level          (in_key_level),
    .in_shift_index        (in_shift_index),
    .in_has_mapping        (in_has_mapping),
    .in_keycode            (in_keycode),
    .in_modifier_mask      (in_modifier_mask),
    .in_modifier_only      (in_modifier_only),
    .in_use_held_modifiers (in_use_held_modifiers),
    .q_full                (q_full),
    .q_wr_en               (q_wr_en),
    .q_wr_data             (q_wr_data)
  );

  // Decouple front and back
  dkr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Execute and report
  dkr_back #(
    .NUM_KEYS  (NUM_KEYS),
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rd_data         (q_rd_data),
    .q_rd_en           (q_rd_en),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_keys          (out_keys),
    .out_modifier_byte (out_report_modifier_byte),
    .out_last          (out_last)
  );

  assign out_report_key0 = out_keys[0];
  assign out_report_key1 = out_keys[1];
  assign out_report_key2 = out_keys[2];
  assign out_report_key3 = out_keys[3];
  assign out_report_key4 = out_keys[4];
  assign out_report_key5 = out_keys[5];

endmodule

`default_nettype wire
